/* sv/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the HSV to ARGB color converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Stream widths
  localparam int IN_W    = 40;   // hue, saturation, brightness, zero pad
  localparam int OUT_W   = 32;
  localparam int HUE_W   = 16;
  localparam int LEVEL_W = 10;

  // Pipeline depth, one valid bit per stage
  localparam int NUM_STAGES = 7;

  localparam logic [7:0] ALPHA = 8'hff;

  // floor(t / 15) == (t * DIV15_RECIP) >> DIV15_SHIFT for every t below 3840
  localparam int          DIV15_W     = 13;
  localparam logic [12:0] DIV15_RECIP = 13'd4370;
  localparam int          DIV15_SHIFT = 16;

  // 60 degree hue sectors
  typedef enum logic [2:0] {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } sector_t;

endpackage

/* sv/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Fixed-point HSV sample to packed ARGB word, seven-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one sample per transaction: hue in 1/64
//   degree steps (any value, wrapped into 0..360), saturation and brightness
//   in 1/256 steps (clamped to 0..1). Output stream m_axis carries one ARGB
//   word per input, alpha 0xff, in input order.
//   Throughput is one sample per clock while m_axis does not stall; the rate
//   is set by the seven register stages, each holding one sample, with no
//   shared unit.
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles collapse and s_axis_tready stays high while any stage is free,
//   also while a result waits on m_axis. When m_axis_tready is low and all
//   stages are full, s_axis_tready drops; nothing is lost or repeated.
//   Reset is synchronous and clears all valid bits, emptying the pipeline.
//   There are no configuration registers.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
  parameter int HUE_FRAC_BITS   = 6,
  parameter int LEVEL_FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // hue [15:0], saturation [25:16], brightness [35:26], zero [39:36]
  input  logic [hsv2rgb_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // argb [31:0]
  output logic [hsv2rgb_pkg::OUT_W-1:0]  m_axis_tdata
);
  import hsv2rgb_pkg::*;

  localparam int FULL    = 360 << HUE_FRAC_BITS;
  localparam int SEC_LEN = 60 << HUE_FRAC_BITS;
  localparam int HW      = $clog2(FULL);
  localparam int RW      = $clog2(SEC_LEN);
  localparam int XW      = ((HW > HUE_W) ? HW : HUE_W) + 1;
  localparam int ONE     = 1 << LEVEL_FRAC_BITS;
  localparam int LW      = LEVEL_FRAC_BITS + 1;
  localparam int MSW     = LW + 8;
  localparam int PW      = RW + MSW;
  localparam int DSH     = HUE_FRAC_BITS + LEVEL_FRAC_BITS + 2;
  localparam int TW      = PW - DSH;
  // Offset between the biased hue and the signed hue, reduced mod FULL
  localparam int HUE_BIAS_MOD = (1 << (HUE_W - 1)) % FULL;
  localparam logic [31:0] FULL_RECIP = 32'(((64'd1) << 32) / FULL);

  // Handshake
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;

  // Stage 1
  logic [HUE_W-1:0] u1;
  logic [HUE_W-1:0] q1;
  logic [LW-1:0]    s1;
  logic [7:0]       mx1;
  // Stage 2
  logic [HUE_W-1:0] r2;
  logic [7:0]       mx2, mn2;
  logic [MSW-1:0]   ms2;
  // Stage 3
  logic [HW-1:0]    h3;
  logic [7:0]       mx3, mn3;
  logic [MSW-1:0]   ms3;
  // Stage 4
  sector_t          sec4;
  logic [RW-1:0]    rem4;
  logic [7:0]       mx4, mn4;
  logic [MSW-1:0]   ms4;
  // Stage 5
  sector_t          sec5;
  logic [TW-1:0]    t5;
  logic [7:0]       mx5, mn5;
  // Stage 6
  sector_t          sec6;
  logic [7:0]       d6, mx6, mn6;
  // Stage 7
  logic [OUT_W-1:0] argb;

  // Input fields
  logic [HUE_W-1:0]          hue;
  logic signed [LEVEL_W-1:0] saturation;
  logic signed [LEVEL_W-1:0] brightness;

  assign hue        = s_axis_tdata[HUE_W-1:0];
  assign saturation = s_axis_tdata[HUE_W+LEVEL_W-1:HUE_W];
  assign brightness = s_axis_tdata[HUE_W+2*LEVEL_W-1:HUE_W+LEVEL_W];

  function automatic logic [LW-1:0] clamp_level(input logic signed [LEVEL_W-1:0] x);
    logic [LW-1:0] y;
    if (x[LEVEL_W-1]) begin
      y = '0;
    end else if (x > ONE) begin
      y = LW'(ONE);
    end else begin
      y = LW'(x);
    end
    return y;
  endfunction

  // Stage 1 combinational
  logic [HUE_W-1:0]       u0;
  logic [HUE_W+31:0]      qprod0;
  logic [LW-1:0]          s0, v0;
  logic [LW+7:0]          vprod0;

  always_comb begin
    u0     = {~hue[HUE_W-1], hue[HUE_W-2:0]};   // bias to unsigned
    qprod0 = (HUE_W+32)'(u0) * (HUE_W+32)'(FULL_RECIP);
    s0     = clamp_level(saturation);
    v0     = clamp_level(brightness);
    vprod0 = (LW+8)'(v0) * (LW+8)'(8'd255);
  end

  // Stage 2 combinational
  logic [31:0]   qfull1;
  logic [LW-1:0] oms1;
  logic [LW+7:0] mnprod1;

  always_comb begin
    qfull1  = 32'(q1) * 32'(FULL);
    oms1    = LW'(ONE) - s1;
    mnprod1 = (LW+8)'(mx1) * (LW+8)'(oms1);
  end

  // Stage 3 combinational: finish u mod FULL, then remove the bias
  logic [XW-1:0] rx2, rw2, hx2;

  always_comb begin
    rx2 = XW'(r2);
    rw2 = (rx2 >= XW'(FULL)) ? rx2 - XW'(FULL) : rx2;
    hx2 = (rw2 >= XW'(HUE_BIAS_MOD)) ? rw2 - XW'(HUE_BIAS_MOD)
                                      : rw2 + XW'(FULL) - XW'(HUE_BIAS_MOD);
  end

  // Stage 4 combinational
  sector_t       sec3;
  logic [RW-1:0] rem3;

  hsv2rgb_sector #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_sector (
    .h      (h3),
    .sector (sec3),
    .rem    (rem3)
  );

  // Stage 5 combinational: rem * max * s, scaled down to 15ths
  logic [PW-1:0] pprod4;

  assign pprod4 = PW'(rem4) * PW'(ms4);

  // Stage 6 combinational: divide by 15
  logic [TW+DIV15_W-1:0] tprod5;

  assign tprod5 = (TW+DIV15_W)'(t5) * (TW+DIV15_W)'(DIV15_RECIP);

  // Stage 7 combinational
  logic [7:0] up6, down6, r6, g6, b6;

  always_comb begin
    up6   = mn6 + d6;
    down6 = mx6 - d6;
    case (sec6)
      SEC_RED_YELLOW:   begin r6 = mx6;   g6 = up6;   b6 = mn6;   end
      SEC_YELLOW_GREEN: begin r6 = down6; g6 = mx6;   b6 = mn6;   end
      SEC_GREEN_CYAN:   begin r6 = mn6;   g6 = mx6;   b6 = up6;   end
      SEC_CYAN_BLUE:    begin r6 = mn6;   g6 = down6; b6 = mx6;   end
      SEC_BLUE_MAGENTA: begin r6 = up6;   g6 = mn6;   b6 = mx6;   end
      default:          begin r6 = mx6;   g6 = mn6;   b6 = down6; end
    endcase
  end

  // Stage advance: empty, or the next stage advances
  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_axis_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= (i == 0) ? s_axis_tvalid : vld[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      u1  <= u0;
      q1  <= qprod0[HUE_W+31:32];
      s1  <= s0;
      mx1 <= vprod0[LEVEL_FRAC_BITS+7:LEVEL_FRAC_BITS];
    end
    if (adv[1]) begin
      r2  <= u1 - qfull1[HUE_W-1:0];
      mx2 <= mx1;
      mn2 <= mnprod1[LEVEL_FRAC_BITS+7:LEVEL_FRAC_BITS];
      ms2 <= MSW'(mx1) * MSW'(s1);
    end
    if (adv[2]) begin
      h3  <= HW'(hx2);
      mx3 <= mx2;
      mn3 <= mn2;
      ms3 <= ms2;
    end
    if (adv[3]) begin
      sec4 <= sec3;
      rem4 <= rem3;
      mx4  <= mx3;
      mn4  <= mn3;
      ms4  <= ms3;
    end
    if (adv[4]) begin
      sec5 <= sec4;
      t5   <= pprod4[PW-1:DSH];
      mx5  <= mx4;
      mn5  <= mn4;
    end
    if (adv[5]) begin
      sec6 <= sec5;
      d6   <= tprod5[DIV15_SHIFT+7:DIV15_SHIFT];
      mx6  <= mx5;
      mn6  <= mn5;
    end
    if (adv[6]) begin
      argb <= {ALPHA, r6, g6, b6};
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[NUM_STAGES-1];
  assign m_axis_tdata  = argb;

  // Assertions
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> mn2 <= mx2)
    else $error("min level above max level");

  a_hue_wrapped: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> h3 < HW'(FULL))
    else $error("wrapped hue out of range");

  a_rem_in_sector: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> rem4 < RW'(SEC_LEN))
    else $error("sector offset out of range");

  a_delta_bounded: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (d6 <= mx6) && (9'(mn6) + 9'(d6) <= 9'(mx6)))
    else $error("sector delta exceeds level span");

endmodule

/* sv/hsv2rgb_sector.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Splits a wrapped hue into its 60 degree sector and the offset inside it.
// ----------------------------------------------------------------------------
module hsv2rgb_sector #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic [$clog2(360 << HUE_FRAC_BITS)-1:0] h,
  output hsv2rgb_pkg::sector_t                    sector,
  output logic [$clog2(60 << HUE_FRAC_BITS)-1:0]  rem
);
  import hsv2rgb_pkg::*;

  localparam int FULL    = 360 << HUE_FRAC_BITS;
  localparam int SEC_LEN = 60 << HUE_FRAC_BITS;
  localparam int HW      = $clog2(FULL);
  localparam int RW      = $clog2(SEC_LEN);

  logic [HW-1:0] base;

  // Independent threshold compares; the highest one passed wins
  always_comb begin
    sector = SEC_RED_YELLOW;
    base   = '0;
    for (int k = 1; k < 6; k++) begin
      if (h >= HW'(k * SEC_LEN)) begin
        sector = sector_t'(3'(k));
        base   = HW'(k * SEC_LEN);
      end
    end
  end

  assign rem = RW'(h - base);

endmodule
